[rtl/ktls_pkg.sv]
package ktls_pkg;

    localparam int MAX_KEYS_DEF = 64;

    // Q16.16 fraction: 33-bit |dt| shifted up by 16 gives a 49-bit numerator
    localparam int NUM_W     = 49;
    localparam int DEN_W     = 33;
    localparam int DIV_STEPS = NUM_W;
    localparam int MUL_STEPS = DEN_W;
    localparam int OPND_W    = 82;
    localparam int STEP_W    = 6;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_ZERO_SPAN = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APPEND,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_RD_T0,
        S_WAIT_T0,
        S_WAIT_V1,
        S_DIV,
        S_MUL_SET,
        S_MUL,
        S_LERP,
        S_LAST_WAIT,
        S_FIN
    } t_state;

endpackage

[rtl/ktls_in_if.sv]
interface ktls_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic        track;
    logic [31:0] time_value;
    logic [31:0] value_x;
    logic [31:0] value_y;
    logic [31:0] value_z;

    modport source (output valid, op, track, time_value, value_x, value_y, value_z,
                    input ready);
    modport sink (input valid, op, track, time_value, value_x, value_y, value_z,
                  output ready);
endinterface

[rtl/ktls_out_if.sv]
interface ktls_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [1:0]  status;

    modport source (output valid, out_x, out_y, out_z, status, input ready);
    modport sink (input valid, out_x, out_y, out_z, status, output ready);
endinterface

[rtl/keyframe_track_lerp_sampler_unit.sv]
// channel   dir  modport  payload
// i_in      in   sink     op, track, time_value, value_x, value_y, value_z
// o_out     out  source   out_x, out_y, out_z, status
//
// One item at a time; i_in.ready is high only while the sequencer is idle.
// Append writes one key. A sample scans the time memory key by key (read, then
// compare); an interpolating sample then runs the 49-step restoring divide and
// three 33-step shift-add multiplies on one shared 82-bit adder.
// Reset clears key counts and control; key memories are not cleared.
// A finished result waits in the output register; a new beat is taken meanwhile.
module keyframe_track_lerp_sampler_unit #(
    parameter int MAX_KEYS = ktls_pkg::MAX_KEYS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ktls_in_if.sink            i_in,
    ktls_out_if.source         o_out
);

    localparam int IDX_W  = $clog2(MAX_KEYS);
    localparam int CNT_W  = $clog2(MAX_KEYS + 1);
    localparam int ADDR_W = IDX_W + 1;
    localparam int DEPTH  = 2 ** ADDR_W;
    localparam int NW     = ktls_pkg::NUM_W;
    localparam int DW     = ktls_pkg::DEN_W;
    localparam int OW     = ktls_pkg::OPND_W;
    localparam int SW     = ktls_pkg::STEP_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_KEYS);

    ktls_pkg::t_state  r_state, n_state;
    ktls_pkg::t_status r_status;

    logic [CNT_W-1:0]  r_key_cnt [2];
    logic              r_track;
    logic signed [31:0] r_t;
    logic [95:0]       r_wvec;
    logic [CNT_W-1:0]  r_j;
    logic signed [31:0] r_t1;
    logic signed [31:0] r_v0 [3];
    logic signed [31:0] r_v1 [3];
    logic signed [31:0] r_res [3];
    logic [NW-1:0]     r_num;
    logic [DW-1:0]     r_den;
    logic [DW-1:0]     r_rem;
    logic              r_fneg;
    logic              r_dneg;
    logic [DW-1:0]     r_ma;
    logic [OW-1:0]     r_mb;
    logic [OW-1:0]     r_acc;
    logic [SW-1:0]     r_step;
    logic [1:0]        r_comp;
    logic              r_out_valid;
    logic [31:0]       r_out_x, r_out_y, r_out_z;
    logic [1:0]        r_out_status;

    logic              accept;
    logic [CNT_W-1:0]  cur_cnt;
    logic [CNT_W-1:0]  last_idx;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_idx;
    logic [ADDR_W-1:0] ram_addr;
    logic [31:0]       time_rdata;
    logic [95:0]       vec_rdata;
    logic              out_free;
    logic              scan_hit;
    logic [CNT_W-1:0]  j_prev;

    // shared adder/subtractor
    logic [OW-1:0]     sh_a, sh_b;
    logic              sh_sub;
    logic [OW:0]       sh_sum;

    logic signed [32:0] dt, span, delta;
    logic [DW-1:0]     dt_mag, span_mag, delta_mag;
    logic [DW:0]       rem2;
    logic              div_ge;
    logic              lerp_neg, lerp_ovf;
    logic [34:0]       lerp_mag;
    logic signed [36:0] v0_ext, lerp_sum;
    logic signed [31:0] lerp_res;

    assign accept   = i_in.valid && i_in.ready;
    assign cur_cnt  = r_key_cnt[r_track];
    assign last_idx = cur_cnt - CNT_W'(1);
    assign out_free = !r_out_valid || o_out.ready;
    assign ram_addr = {r_track, ram_idx};
    assign scan_hit = r_t < $signed(time_rdata);
    assign j_prev   = r_j - CNT_W'(1);

    assign sh_sum = {1'b0, sh_a} + {1'b0, (sh_sub ? ~sh_b : sh_b)} + (OW+1)'(sh_sub);

    assign dt       = {r_t[31], r_t} - {time_rdata[31], time_rdata};
    assign span     = {r_t1[31], r_t1} - {time_rdata[31], time_rdata};
    assign dt_mag   = dt[32] ? DW'(-dt) : DW'(dt);
    assign span_mag = span[32] ? DW'(-span) : DW'(span);
    assign delta    = {r_v1[r_comp][31], r_v1[r_comp]} - {r_v0[r_comp][31], r_v0[r_comp]};
    assign delta_mag = delta[32] ? DW'(-delta) : DW'(delta);
    assign rem2     = {r_rem, r_num[NW-1]};
    assign div_ge   = sh_sum[OW];

    // product above 2^50 saturates
    assign lerp_neg = r_dneg ^ r_fneg;
    assign lerp_ovf = (r_acc[OW-1:51] != '0) || (r_acc[50] && (r_acc[49:0] != '0));
    assign lerp_mag = r_acc[50:16];
    assign v0_ext   = 37'(r_v0[r_comp]);
    assign lerp_sum = lerp_neg ? v0_ext - $signed({2'b00, lerp_mag})
                               : v0_ext + $signed({2'b00, lerp_mag});

    always_comb begin
        if (lerp_ovf) begin
            lerp_res = lerp_neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else if (lerp_sum > 37'sd2147483647) begin
            lerp_res = 32'sh7fff_ffff;
        end else if (lerp_sum < -37'sd2147483648) begin
            lerp_res = 32'sh8000_0000;
        end else begin
            lerp_res = lerp_sum[31:0];
        end
    end

    ktls_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_time_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(r_t),
        .o_rdata(time_rdata)
    );

    ktls_ram #(.WIDTH(96), .DEPTH(DEPTH)) u_vec_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(r_wvec),
        .o_rdata(vec_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ktls_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_in.op == ktls_pkg::OP_APPEND) begin
                        n_state = ktls_pkg::S_APPEND;
                    end else if (r_key_cnt[i_in.track] == '0) begin
                        n_state = ktls_pkg::S_FIN;
                    end else begin
                        n_state = ktls_pkg::S_SCAN_RD;
                    end
                end
            end
            ktls_pkg::S_APPEND:    n_state = ktls_pkg::S_FIN;
            ktls_pkg::S_SCAN_RD: begin
                n_state = (r_j >= cur_cnt) ? ktls_pkg::S_LAST_WAIT : ktls_pkg::S_SCAN_CMP;
            end
            ktls_pkg::S_SCAN_CMP: begin
                n_state = scan_hit ? ktls_pkg::S_RD_T0 : ktls_pkg::S_SCAN_RD;
            end
            ktls_pkg::S_RD_T0:     n_state = ktls_pkg::S_WAIT_T0;
            ktls_pkg::S_WAIT_T0: begin
                n_state = (span == '0) ? ktls_pkg::S_FIN : ktls_pkg::S_WAIT_V1;
            end
            ktls_pkg::S_WAIT_V1:   n_state = ktls_pkg::S_DIV;
            ktls_pkg::S_DIV: begin
                if (r_step == SW'(ktls_pkg::DIV_STEPS - 1)) begin
                    n_state = ktls_pkg::S_MUL_SET;
                end
            end
            ktls_pkg::S_MUL_SET:   n_state = ktls_pkg::S_MUL;
            ktls_pkg::S_MUL: begin
                if (r_step == SW'(ktls_pkg::MUL_STEPS - 1)) begin
                    n_state = ktls_pkg::S_LERP;
                end
            end
            ktls_pkg::S_LERP: begin
                n_state = (r_comp == 2'd2) ? ktls_pkg::S_FIN : ktls_pkg::S_MUL_SET;
            end
            ktls_pkg::S_LAST_WAIT: n_state = ktls_pkg::S_FIN;
            ktls_pkg::S_FIN: begin
                if (out_free) begin
                    n_state = ktls_pkg::S_IDLE;
                end
            end
            default:               n_state = ktls_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        i_in.ready = 1'b0;
        ram_we     = 1'b0;
        ram_idx    = '0;
        sh_a       = '0;
        sh_b       = '0;
        sh_sub     = 1'b0;
        case (r_state)
            ktls_pkg::S_IDLE:      i_in.ready = 1'b1;
            ktls_pkg::S_APPEND: begin
                ram_idx = cur_cnt[IDX_W-1:0];
                ram_we  = cur_cnt < MAX_CNT;
            end
            ktls_pkg::S_SCAN_RD: begin
                ram_idx = (r_j >= cur_cnt) ? last_idx[IDX_W-1:0] : r_j[IDX_W-1:0];
            end
            ktls_pkg::S_RD_T0:     ram_idx = j_prev[IDX_W-1:0];
            ktls_pkg::S_WAIT_T0:   ram_idx = r_j[IDX_W-1:0];
            ktls_pkg::S_DIV: begin
                sh_a   = OW'(rem2);
                sh_b   = OW'(r_den);
                sh_sub = 1'b1;
            end
            ktls_pkg::S_MUL: begin
                sh_a = r_acc;
                sh_b = r_ma[0] ? r_mb : '0;
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ktls_pkg::S_IDLE;
            r_key_cnt[0] <= '0;
            r_key_cnt[1] <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ram_we) begin
                r_key_cnt[r_track] <= cur_cnt + CNT_W'(1);
            end
            if (r_state == ktls_pkg::S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ktls_pkg::S_IDLE: begin
                if (accept) begin
                    r_track  <= i_in.track;
                    r_t      <= i_in.time_value;
                    r_wvec   <= {i_in.value_z, i_in.value_y, i_in.value_x};
                    r_res[0] <= '0;
                    r_res[1] <= '0;
                    r_res[2] <= '0;
                    r_j      <= CNT_W'(1);
                    r_status <= (i_in.op == ktls_pkg::OP_SAMPLE
                                 && r_key_cnt[i_in.track] == '0)
                                ? ktls_pkg::ST_EMPTY : ktls_pkg::ST_OK;
                end
            end
            ktls_pkg::S_APPEND: begin
                if (cur_cnt >= MAX_CNT) begin
                    r_status <= ktls_pkg::ST_FULL;
                end
            end
            ktls_pkg::S_SCAN_CMP: begin
                if (scan_hit) begin
                    r_t1 <= $signed(time_rdata);
                end else begin
                    r_j <= r_j + CNT_W'(1);
                end
            end
            ktls_pkg::S_WAIT_T0: begin
                r_v0[0] <= vec_rdata[31:0];
                r_v0[1] <= vec_rdata[63:32];
                r_v0[2] <= vec_rdata[95:64];
                if (span == '0) begin
                    r_status <= ktls_pkg::ST_ZERO_SPAN;
                    r_res[0] <= vec_rdata[31:0];
                    r_res[1] <= vec_rdata[63:32];
                    r_res[2] <= vec_rdata[95:64];
                end
                r_num  <= {dt_mag, 16'b0};
                r_den  <= span_mag;
                r_fneg <= dt[32] ^ span[32];
                r_rem  <= '0;
                r_step <= '0;
                r_comp <= '0;
            end
            ktls_pkg::S_WAIT_V1: begin
                r_v1[0] <= vec_rdata[31:0];
                r_v1[1] <= vec_rdata[63:32];
                r_v1[2] <= vec_rdata[95:64];
            end
            ktls_pkg::S_DIV: begin
                // restoring divide; quotient bits shift into r_num
                r_rem  <= div_ge ? sh_sum[DW-1:0] : rem2[DW-1:0];
                r_num  <= {r_num[NW-2:0], div_ge};
                r_step <= r_step + SW'(1);
            end
            ktls_pkg::S_MUL_SET: begin
                r_ma   <= delta_mag;
                r_dneg <= delta[32];
                r_mb   <= OW'(r_num);
                r_acc  <= '0;
                r_step <= '0;
            end
            ktls_pkg::S_MUL: begin
                r_acc  <= sh_sum[OW-1:0];
                r_ma   <= r_ma >> 1;
                r_mb   <= r_mb << 1;
                r_step <= r_step + SW'(1);
            end
            ktls_pkg::S_LERP: begin
                r_res[r_comp] <= lerp_res;
                r_comp        <= r_comp + 2'd1;
            end
            ktls_pkg::S_LAST_WAIT: begin
                r_res[0] <= vec_rdata[31:0];
                r_res[1] <= vec_rdata[63:32];
                r_res[2] <= vec_rdata[95:64];
            end
            ktls_pkg::S_FIN: begin
                if (out_free) begin
                    r_out_x      <= r_res[0];
                    r_out_y      <= r_res[1];
                    r_out_z      <= r_res[2];
                    r_out_status <= r_status;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.out_x  = r_out_x;
    assign o_out.out_y  = r_out_y;
    assign o_out.out_z  = r_out_z;
    assign o_out.status = r_out_status;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_key_cnt[0] <= MAX_CNT) && (r_key_cnt[1] <= MAX_CNT))
        else $error("key count past capacity");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ktls_pkg::S_DIV) |-> (r_den != '0))
        else $error("divide with zero span");

    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ktls_pkg::S_APPEND && cur_cnt < MAX_CNT)
        |=> (r_key_cnt[r_track] == $past(cur_cnt) + CNT_W'(1)))
        else $error("append did not bump count");

    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ktls_pkg::S_FIN && out_free) |=> o_out.valid)
        else $error("finished result not presented");
`endif

endmodule

[rtl/ktls_ram.sv]
module ktls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

[test/keyframe_track_lerp_sampler_checker.sv]
`timescale 1ns / 1ps

module keyframe_track_lerp_sampler_checker #(
    parameter int MAX_KEYS = ktls_pkg::MAX_KEYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_op,
    input  logic        i_track,
    input  logic [31:0] i_time_value,
    input  logic [31:0] i_value_x,
    input  logic [31:0] i_value_y,
    input  logic [31:0] i_value_z,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_x,
    input  logic [31:0] i_out_y,
    input  logic [31:0] i_out_z,
    input  logic [1:0]  i_status,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [31:0]       x;
        logic [31:0]       y;
        logic [31:0]       z;
        ktls_pkg::t_status status;
    } t_sample;

    logic signed [31:0] key_time [2][MAX_KEYS];
    logic signed [31:0] key_vec  [2][MAX_KEYS][3];
    int                 key_num  [2];
    t_sample            sample_queue[$];

    assign o_pending = sample_queue.size();

    function automatic logic signed [31:0] lerp_q16(logic signed [31:0] v0,
                                                    logic signed [31:0] v1,
                                                    longint frac);
        longint delta;
        longint a;
        longint b;
        longint mag;
        longint r;
        bit     neg;
        delta = longint'(v1) - longint'(v0);
        if (delta == 0 || frac == 0) return v0;
        neg = (delta < 0) != (frac < 0);
        a = delta < 0 ? -delta : delta;
        b = frac < 0 ? -frac : frac;
        if (b > ((64'sd1 <<< 50) / a)) return neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        mag = (a * b) >>> 16;
        r = neg ? longint'(v0) - mag : longint'(v0) + mag;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic t_sample predict_sample(logic op, logic tr, logic signed [31:0] t,
                                               logic signed [31:0] vx,
                                               logic signed [31:0] vy,
                                               logic signed [31:0] vz);
        t_sample res;
        int      n;
        int      sel;
        longint  span;
        longint  frac;
        logic signed [31:0] r [3];
        res = '{x: '0, y: '0, z: '0, status: ktls_pkg::ST_OK};
        n = key_num[tr];
        r = '{0, 0, 0};
        if (op == ktls_pkg::OP_APPEND) begin
            if (n >= MAX_KEYS) begin
                res.status = ktls_pkg::ST_FULL;
            end else begin
                key_time[tr][n] = t;
                key_vec[tr][n][0] = vx;
                key_vec[tr][n][1] = vy;
                key_vec[tr][n][2] = vz;
                key_num[tr] = n + 1;
            end
            return res;
        end
        if (n == 0) begin
            res.status = ktls_pkg::ST_EMPTY;
            return res;
        end
        sel = -1;
        for (int i = 0; i + 1 < n; i++) begin
            if (t < key_time[tr][i+1]) begin
                sel = i;
                break;
            end
        end
        if (sel < 0) begin
            for (int k = 0; k < 3; k++) r[k] = key_vec[tr][n-1][k];
        end else begin
            span = longint'(key_time[tr][sel+1]) - longint'(key_time[tr][sel]);
            if (span == 0) begin
                res.status = ktls_pkg::ST_ZERO_SPAN;
                for (int k = 0; k < 3; k++) r[k] = key_vec[tr][sel][k];
            end else begin
                frac = ((longint'(t) - longint'(key_time[tr][sel])) * 65536) / span;
                for (int k = 0; k < 3; k++)
                    r[k] = lerp_q16(key_vec[tr][sel][k], key_vec[tr][sel+1][k], frac);
            end
        end
        res.x = r[0];
        res.y = r[1];
        res.z = r[2];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        key_num = '{0, 0};
    end

    always @(posedge i_clk) begin
        t_sample exp_s;
        if (!i_rst_n) begin
            key_num = '{0, 0};
            sample_queue.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (sample_queue.size() == 0) begin
                    report_mismatch("unexpected beat", i_out_x, '0);
                end else begin
                    exp_s = sample_queue.pop_front();
                    if (i_out_x !== exp_s.x) report_mismatch("out_x", i_out_x, exp_s.x);
                    if (i_out_y !== exp_s.y) report_mismatch("out_y", i_out_y, exp_s.y);
                    if (i_out_z !== exp_s.z) report_mismatch("out_z", i_out_z, exp_s.z);
                    if (i_status !== exp_s.status)
                        report_mismatch("status", 32'(i_status), 32'(exp_s.status));
                end
            end
            if (i_in_valid && i_in_ready)
                sample_queue.push_back(predict_sample(i_op, i_track, i_time_value,
                                                      i_value_x, i_value_y, i_value_z));
        end
    end
endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam int MAX_KEYS = ktls_pkg::MAX_KEYS_DEF;
    localparam int N_RANDOM = 770;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    bit   hold_sink = 1'b0;
    bit   calm = 1'b0;
    bit   done_stim = 1'b0;

    ktls_in_if  in_ch();
    ktls_out_if out_ch();

    keyframe_track_lerp_sampler_unit #(.MAX_KEYS(MAX_KEYS)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    keyframe_track_lerp_sampler_checker #(.MAX_KEYS(MAX_KEYS)) u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_op         (in_ch.op),
        .i_track      (in_ch.track),
        .i_time_value (in_ch.time_value),
        .i_value_x    (in_ch.value_x),
        .i_value_y    (in_ch.value_y),
        .i_value_z    (in_ch.value_z),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_x      (out_ch.out_x),
        .i_out_y      (out_ch.out_y),
        .i_out_z      (out_ch.out_z),
        .i_status     (out_ch.status),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.op = ktls_pkg::OP_APPEND;
        in_ch.track = 1'b0;
        in_ch.time_value = '0;
        in_ch.value_x = '0;
        in_ch.value_y = '0;
        in_ch.value_z = '0;
        out_ch.ready = 1'b0;
    end

    // sink side: random stalls, quiet window, one long forced hold-off
    always @(posedge i_clk) begin
        if (hold_sink) out_ch.ready <= 1'b0;
        else if (calm) out_ch.ready <= 1'b1;
        else out_ch.ready <= ($urandom_range(99) >= 22);
    end

    initial begin
        wait (i_rst_n);
        repeat (3000) @(posedge i_clk);
        hold_sink = 1'b1;
        repeat (1500) @(posedge i_clk);
        hold_sink = 1'b0;
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(8) - 4;
            default: return $urandom();
        endcase
    endfunction

    // drives one beat; valid stays high across back-to-back beats
    task automatic send_beat(logic op, logic tr, logic [31:0] t,
                             logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
        while (!calm && $urandom_range(99) < 22) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.track <= tr;
        in_ch.time_value <= t;
        in_ch.value_x <= vx;
        in_ch.value_y <= vy;
        in_ch.value_z <= vz;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain_all();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // ascending track of random keys, times spaced by a random step
    task automatic fill_track(logic tr, int count, int step_max);
        logic [31:0] t;
        t = 32'($signed(-$urandom_range(400000)));
        for (int i = 0; i < count; i++) begin
            send_beat(ktls_pkg::OP_APPEND, tr, t, rand_word(), rand_word(), rand_word());
            t = t + $urandom_range(step_max, 1);
        end
    endtask

    initial begin
        logic [31:0] qt;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty, single key, extremes, zero span, extrapolation
        send_beat(ktls_pkg::OP_SAMPLE, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_beat(ktls_pkg::OP_SAMPLE, 1'b1, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                  32'hffff_ffff);
        send_beat(ktls_pkg::OP_APPEND, 1'b0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                  32'h0);
        send_beat(ktls_pkg::OP_SAMPLE, 1'b0, 32'h7fff_ffff, 32'h0, 32'h0, 32'h0);
        send_beat(ktls_pkg::OP_APPEND, 1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                  32'hffff_ffff);
        send_beat(ktls_pkg::OP_SAMPLE, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_beat(ktls_pkg::OP_SAMPLE, 1'b0, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
        send_beat(ktls_pkg::OP_SAMPLE, 1'b0, 32'h7fff_ffff, 32'h0, 32'h0, 32'h0);
        send_beat(ktls_pkg::OP_APPEND, 1'b1, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
        send_beat(ktls_pkg::OP_APPEND, 1'b1, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0);
        send_beat(ktls_pkg::OP_APPEND, 1'b1, 32'h0000_8000, 32'h7fff_ffff, 32'h8000_0000,
                  32'h1);
        send_beat(ktls_pkg::OP_SAMPLE, 1'b1, 32'h0, 32'h0, 32'h0, 32'h0);
        send_beat(ktls_pkg::OP_SAMPLE, 1'b1, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
        send_beat(ktls_pkg::OP_SAMPLE, 1'b1, 32'h0000_4000, 32'h0, 32'h0, 32'h0);
        send_beat(ktls_pkg::OP_SAMPLE, 1'b1, 32'h7fff_ffff, 32'h0, 32'h0, 32'h0);
        drain_all();

        // fill position track to full, then one overflow append
        fill_track(1'b0, MAX_KEYS - 2, 3000);
        send_beat(ktls_pkg::OP_APPEND, 1'b0, 32'h7fff_ffff, 32'h1, 32'h2, 32'h3);
        send_beat(ktls_pkg::OP_SAMPLE, 1'b0, 32'h7fff_fffe, 32'h0, 32'h0, 32'h0);
        drain_all();

        // random: mostly samples on the full track 0 and the small track 1, plus random appends
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 150) calm = 1'b1;
            if (n == 250) calm = 1'b0;
            if (n == 500) drain_all();
            case ($urandom_range(9))
                0: send_beat(ktls_pkg::OP_APPEND, 1'($urandom_range(1)), rand_word(),
                             rand_word(), rand_word(), rand_word());
                1, 2, 3, 4, 5: begin
                    qt = ($urandom_range(3) == 0) ? rand_word()
                         : 32'($signed(-$urandom_range(400000)) +
                               $signed($urandom_range(250000)));
                    send_beat(ktls_pkg::OP_SAMPLE, 1'b0, qt, rand_word(), rand_word(),
                              rand_word());
                end
                default: begin
                    qt = ($urandom_range(2) == 0) ? rand_word() : $urandom_range(60000);
                    send_beat(ktls_pkg::OP_SAMPLE, 1'b1, qt, rand_word(), rand_word(),
                              rand_word());
                end
            endcase
        end
        in_ch.valid <= 1'b0;
        done_stim = 1'b1;
    end

    initial begin
        wait (done_stim);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

[sim.f]
rtl/ktls_pkg.sv
rtl/ktls_in_if.sv
rtl/ktls_out_if.sv
rtl/ktls_ram.sv
rtl/keyframe_track_lerp_sampler_unit.sv
test/keyframe_track_lerp_sampler_checker.sv
test/tb.sv
